FILE: src/pes_hdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PES header parser package
// Shared payload types, parse phases and field helpers.
// ----------------------------------------------------------------------------
package pes_hdr_pkg;

    localparam int unsigned FIXED_HEADER_BYTES = 9;

    // Byte positions in the fixed part of the header
    localparam logic [15:0] POS_STREAM  = 16'd3;
    localparam logic [15:0] POS_LEN_HI  = 16'd4;
    localparam logic [15:0] POS_LEN_LO  = 16'd5;
    localparam logic [15:0] POS_FLAG_HI = 16'd6;
    localparam logic [15:0] POS_FLAG_LO = 16'd7;
    localparam logic [15:0] POS_HDR_LEN = 16'd8;

    localparam logic [8:0] SPECIAL_OFFSET = 9'd6;

    typedef enum logic [3:0] {
        PH_FIXED = 4'd0,
        PH_PTS   = 4'd1,
        PH_DTS   = 4'd2,
        PH_ESCR  = 4'd3,
        PH_RATE  = 4'd4,
        PH_TRICK = 4'd5,
        PH_COPY  = 4'd6,
        PH_CRC   = 4'd7,
        PH_SKIP  = 4'd8,
        PH_DONE  = 4'd9,
        PH_BAD   = 4'd10
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic        header_ok;
        logic [7:0]  stream_code;
        logic [15:0] packet_length;
        logic [15:0] header_flags;
        logic [32:0] pts_value;
        logic [32:0] dts_value;
        logic [32:0] escr_base_value;
        logic [8:0]  escr_ext_value;
        logic [21:0] es_rate_value;
        logic [7:0]  trick_byte;
        logic [15:0] prev_crc;
        logic [8:0]  payload_offset;
    } t_out;

    // Phase choice after a field or the fixed header ends
    typedef struct packed {
        t_phase     phase;
        logic [7:0] skip;
        logic       done;
        logic       clr_shift;
    } t_adv;

    function automatic logic [2:0] field_len(input t_phase ph);
        logic [2:0] len;
        case (ph)
            PH_PTS, PH_DTS:    len = 3'd5;
            PH_ESCR:           len = 3'd6;
            PH_RATE:           len = 3'd3;
            PH_TRICK, PH_COPY: len = 3'd1;
            PH_CRC:            len = 3'd2;
            default:           len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic special_id(input logic [7:0] id);
        return (id == 8'hBC) || (id == 8'hBE) || (id == 8'hBF) || (id == 8'hF0) ||
               (id == 8'hF1) || (id == 8'hF2) || (id == 8'hF8) || (id == 8'hFF);
    endfunction

endpackage

FILE: src/pes_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PES packet header parser
// Byte-wide parser for MPEG-2 PES headers with one result per packet.
// ----------------------------------------------------------------------------
// Takes one byte of a PES packet per transaction, one transaction per cycle,
// with last_byte marking the final byte of the buffer. Each byte goes through
// a single register-to-register pass that updates the parse state; on the
// last byte the captured fields, the payload offset and the header_ok flag
// are loaded into the output register as one result transaction, and the
// parser clears itself for the next packet. Bytes that are not last never
// stall, even while a result waits; only a last byte stalls while the
// output register is still held by the downstream side.
module pes_header_parser
    import pes_hdr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    // Parse state
    logic [15:0] r_pos,       n_pos;
    t_phase      r_phase,     n_phase;
    logic [39:0] r_shift,     n_shift;
    logic [7:0]  r_skip,      n_skip;
    logic [7:0]  r_hl,        n_hl;
    logic        r_done,      n_done;
    logic        r_special,   n_special;
    // Captured fields
    logic [7:0]  r_stream,    n_stream;
    logic [15:0] r_len,       n_len;
    logic [15:0] r_flags,     n_flags;
    logic [32:0] r_pts,       n_pts;
    logic [32:0] r_dts,       n_dts;
    logic [32:0] r_escr_base, n_escr_base;
    logic [8:0]  r_escr_ext,  n_escr_ext;
    logic [21:0] r_rate,      n_rate;
    logic [7:0]  r_trick,     n_trick;
    logic [15:0] r_crc,       n_crc;

    logic        r_out_valid;
    t_out        r_out;
    t_out        n_out;

    logic        accept;
    logic [7:0]  b;
    t_adv        adv;
    logic [8:0]  offset;

    // Stall only a last byte that would overwrite a held result
    assign o_in_stall  = r_out_valid & i_out_stall & i_in_data.last_byte;
    assign accept      = i_in_valid & ~o_in_stall;
    assign b           = i_in_data.data_byte;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    pes_hdr_advance u_advance (
        .i_from    (r_phase),
        .i_flags   (r_flags[7:0]),
        .i_used    (r_pos[9:0] - 10'd8),
        .i_hdr_len ((r_phase == PH_FIXED) ? b : r_hl),
        .o_adv     (adv)
    );

    // Next parse state for the byte on the input
    always_comb begin
        n_pos       = (r_pos == 16'hFFFF) ? r_pos : r_pos + 16'd1;
        n_phase     = r_phase;
        n_shift     = r_shift;
        n_skip      = r_skip;
        n_hl        = r_hl;
        n_done      = r_done;
        n_special   = r_special;
        n_stream    = r_stream;
        n_len       = r_len;
        n_flags     = r_flags;
        n_pts       = r_pts;
        n_dts       = r_dts;
        n_escr_base = r_escr_base;
        n_escr_ext  = r_escr_ext;
        n_rate      = r_rate;
        n_trick     = r_trick;
        n_crc       = r_crc;
        unique case (r_phase)
            PH_FIXED: begin
                if (r_pos == POS_STREAM) begin
                    n_stream  = b;
                    n_special = special_id(b);
                end else if (r_pos == POS_LEN_HI) begin
                    n_len[15:8] = b;
                end else if (r_pos == POS_LEN_LO) begin
                    n_len[7:0] = b;
                    // special streams end the header here
                    if (r_special) begin
                        n_phase = PH_DONE;
                        n_done  = 1'b1;
                    end
                end else if (r_pos == POS_FLAG_HI) begin
                    n_flags[15:8] = b;
                end else if (r_pos == POS_FLAG_LO) begin
                    n_flags[7:0] = b;
                end else if (r_pos == POS_HDR_LEN) begin
                    n_hl    = b;
                    n_phase = adv.phase;
                    n_skip  = adv.skip;
                    n_done  = adv.done;
                    if (adv.clr_shift) begin
                        n_shift = 40'd0;
                    end
                end
            end
            PH_PTS, PH_DTS, PH_ESCR, PH_RATE, PH_TRICK, PH_COPY, PH_CRC: begin
                // first ESCR byte holds the top five base bits
                if (r_phase == PH_ESCR && r_skip == 8'd6) begin
                    n_escr_base = {b[5:3], b[1:0], 28'd0};
                    n_escr_ext  = 9'd0;
                end else begin
                    n_shift = {r_shift[31:0], b};
                end
                n_skip = r_skip - 8'd1;
                if (n_skip == 8'd0) begin
                    case (r_phase)
                        PH_PTS:   n_pts = {n_shift[35:33], n_shift[31:17], n_shift[15:1]};
                        PH_DTS:   n_dts = {n_shift[35:33], n_shift[31:17], n_shift[15:1]};
                        PH_ESCR: begin
                            n_escr_base = {r_escr_base[32:28], n_shift[39:27],
                                           n_shift[25:11]};
                            n_escr_ext  = n_shift[9:1];
                        end
                        PH_RATE:  n_rate  = n_shift[22:1];
                        PH_TRICK: n_trick = n_shift[7:0];
                        PH_CRC:   n_crc   = n_shift[15:0];
                        default: ;
                    endcase
                    n_phase = adv.phase;
                    n_skip  = adv.skip;
                    n_done  = r_done | adv.done;
                    if (adv.clr_shift) begin
                        n_shift = 40'd0;
                    end
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 8'd1;
                if (n_skip == 8'd0) begin
                    n_phase = PH_DONE;
                    n_done  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result for a last byte, built from the updated state
    always_comb begin
        if (n_pos >= 16'd4 && n_special) begin
            offset = SPECIAL_OFFSET;
        end else if (n_pos >= 16'(FIXED_HEADER_BYTES) && !n_special) begin
            offset = 9'(FIXED_HEADER_BYTES) + {1'b0, n_hl};
        end else begin
            offset = 9'd0;
        end
        n_out.header_ok       = n_done;
        n_out.stream_code     = n_stream;
        n_out.packet_length   = n_len;
        n_out.header_flags    = n_flags;
        n_out.pts_value       = n_pts;
        n_out.dts_value       = n_dts;
        // ESCR cut short reads as absent
        n_out.escr_base_value = (n_phase == PH_ESCR) ? 33'd0 : n_escr_base;
        n_out.escr_ext_value  = (n_phase == PH_ESCR) ? 9'd0 : n_escr_ext;
        n_out.es_rate_value   = n_rate;
        n_out.trick_byte      = n_trick;
        n_out.prev_crc        = n_crc;
        n_out.payload_offset  = offset;
    end

    // Parse state: clear on reset and after each packet's last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in_data.last_byte)) begin
            r_pos       <= 16'd0;
            r_phase     <= PH_FIXED;
            r_shift     <= 40'd0;
            r_skip      <= 8'd0;
            r_hl        <= 8'd0;
            r_done      <= 1'b0;
            r_special   <= 1'b0;
            r_stream    <= 8'd0;
            r_len       <= 16'd0;
            r_flags     <= 16'd0;
            r_pts       <= 33'd0;
            r_dts       <= 33'd0;
            r_escr_base <= 33'd0;
            r_escr_ext  <= 9'd0;
            r_rate      <= 22'd0;
            r_trick     <= 8'd0;
            r_crc       <= 16'd0;
        end else if (accept) begin
            r_pos       <= n_pos;
            r_phase     <= n_phase;
            r_shift     <= n_shift;
            r_skip      <= n_skip;
            r_hl        <= n_hl;
            r_done      <= n_done;
            r_special   <= n_special;
            r_stream    <= n_stream;
            r_len       <= n_len;
            r_flags     <= n_flags;
            r_pts       <= n_pts;
            r_dts       <= n_dts;
            r_escr_base <= n_escr_base;
            r_escr_ext  <= n_escr_ext;
            r_rate      <= n_rate;
            r_trick     <= n_trick;
            r_crc       <= n_crc;
        end
    end

    // Output register: load on a last byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_in_data.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_in_data.last_byte) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: src/pes_hdr_advance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PES header phase chooser
// Picks the next flagged field, or bad if it does not fit, else skip or done.
// ----------------------------------------------------------------------------
module pes_hdr_advance
    import pes_hdr_pkg::*;
(
    input  t_phase     i_from,
    input  logic [7:0] i_flags,
    input  logic [9:0] i_used,
    input  logic [7:0] i_hdr_len,
    output t_adv       o_adv
);

    logic [7:0] on;
    logic [7:0] after;
    logic       found;
    t_phase     sel;

    always_comb begin
        on       = 8'd0;
        on[1]    = i_flags[7];
        on[2]    = i_flags[7] & i_flags[6];
        on[3]    = i_flags[5];
        on[4]    = i_flags[4];
        on[5]    = i_flags[3];
        on[6]    = i_flags[2];
        on[7]    = i_flags[1];
        after    = 8'd0;
        found    = 1'b0;
        sel      = PH_DONE;
        for (int p = 1; p < 8; p++) begin
            after[p] = (4'(p) > i_from);
        end
        // first enabled phase after the current one
        for (int p = 7; p >= 1; p--) begin
            if (on[p] && after[p]) begin
                found = 1'b1;
                sel   = t_phase'(4'(p));
            end
        end
    end

    always_comb begin
        o_adv = '{phase: PH_DONE, skip: 8'd0, done: 1'b0, clr_shift: 1'b0};
        if (found) begin
            if ((i_used + 10'(field_len(sel))) > {2'b00, i_hdr_len}) begin
                o_adv.phase = PH_BAD;
            end else begin
                o_adv.phase     = sel;
                o_adv.skip      = {5'd0, field_len(sel)};
                o_adv.clr_shift = 1'b1;
            end
        end else if (i_used >= {2'b00, i_hdr_len}) begin
            o_adv.phase = PH_DONE;
            o_adv.done  = 1'b1;
        end else begin
            o_adv.phase = PH_SKIP;
            o_adv.skip  = 8'({2'b00, i_hdr_len} - i_used);
        end
    end

endmodule
